### rtl/core/imtr_pkg.sv
// Package: constants and word types of the interval min/max/average tracker.
`timescale 1ns / 1ps
package imtr_pkg;

  localparam int TIMER_PERIOD = 255;
  localparam int AVG_WINDOW   = 255;

  localparam logic [7:0]  TIMER_PERIOD_LO = 8'(TIMER_PERIOD);
  localparam logic [16:0] AVG_WINDOW_W    = 17'(AVG_WINDOW);
  localparam logic [16:0] AVG_DIV_W       = 17'(AVG_WINDOW + 1);

  localparam logic CMD_SNAPSHOT = 1'b0;
  localparam logic CMD_RESTART  = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] timer_value;
  } imtr_in_t;

  typedef struct packed {
    logic [7:0] elapsed_ticks;
    logic [7:0] min_ticks;
    logic [7:0] max_ticks;
    logic [7:0] avg_ticks;
    logic       avg_updated;
  } imtr_res_t;

endpackage

### rtl/core/imtr_if.sv
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface imtr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] timer_value;

  modport source (output valid, cmd, timer_value, input ready);
  modport sink   (input valid, cmd, timer_value, output ready);
endinterface

interface imtr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] elapsed_ticks;
  logic [7:0] min_ticks;
  logic [7:0] max_ticks;
  logic [7:0] avg_ticks;
  logic       avg_updated;

  modport source (output valid, elapsed_ticks, min_ticks, max_ticks, avg_ticks, avg_updated,
                  input ready);
  modport sink   (input valid, elapsed_ticks, min_ticks, max_ticks, avg_ticks, avg_updated,
                  output ready);
endinterface

### rtl/core/imtr_in_reg.sv
// Input register: holds one accepted word until the update stage takes it.
`timescale 1ns / 1ps
module imtr_in_reg import imtr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     ready_o,
  input  imtr_in_t word_i,
  output logic     valid_o,
  input  logic     ready_i,
  output imtr_in_t word_o
);

  logic     valid_q, valid_d;
  imtr_in_t word_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q <= word_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

### rtl/core/imtr_core.sv
// Update stage: statistics state, one-pass update and result register.
`timescale 1ns / 1ps
module imtr_core import imtr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  imtr_in_t  word_i,
  output logic      valid_o,
  input  logic      ready_i,
  output imtr_res_t res_o
);

  logic        pending_q, pending_d;
  logic [7:0]  prev_q, prev_d;
  logic [7:0]  min_q, min_d;
  logic [7:0]  max_q, max_d;
  logic [7:0]  avg_q, avg_d;
  logic [15:0] sum_q, sum_d;
  logic [8:0]  count_q, count_d;
  logic        out_valid_q, out_valid_d;
  imtr_res_t   res_q, res_d;

  logic        take;
  logic [7:0]  elapsed;
  logic [16:0] sum_wide;
  logic [15:0] sum_sat;
  logic [8:0]  count_inc;
  logic [16:0] quot;
  logic        window_done;

  assign ready_o = !out_valid_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    elapsed     = (word_i.timer_value >= prev_q) ? word_i.timer_value - prev_q
                : TIMER_PERIOD_LO - (prev_q - word_i.timer_value);
    sum_wide    = {1'b0, sum_q} + {9'b0, elapsed};
    sum_sat     = sum_wide[16] ? 16'hFFFF : sum_wide[15:0];
    count_inc   = count_q + 9'd1;
    window_done = {8'b0, count_inc} > AVG_WINDOW_W;
    quot        = {1'b0, sum_sat} / AVG_DIV_W;
  end

  always_comb begin
    pending_d = pending_q;
    prev_d    = prev_q;
    min_d     = min_q;
    max_d     = max_q;
    avg_d     = avg_q;
    sum_d     = sum_q;
    count_d   = count_q;
    res_d     = res_q;
    res_d.elapsed_ticks = 8'd0;
    res_d.avg_updated   = 1'b0;
    if (word_i.cmd == CMD_RESTART) begin
      pending_d = 1'b1;
    end else if (pending_q) begin
      pending_d = 1'b0;
      prev_d    = word_i.timer_value;
      min_d     = TIMER_PERIOD_LO;
      max_d     = 8'd0;
      avg_d     = 8'd0;
      sum_d     = 16'd0;
      count_d   = 9'd0;
    end else begin
      prev_d = word_i.timer_value;
      res_d.elapsed_ticks = elapsed;
      if (elapsed < min_q) begin
        min_d = elapsed;
      end
      if (elapsed > max_q) begin
        max_d = elapsed;
      end
      if (window_done) begin
        avg_d   = (quot > 17'd255) ? 8'hFF : quot[7:0];
        sum_d   = 16'd0;
        count_d = 9'd0;
        res_d.avg_updated = 1'b1;
      end else begin
        sum_d   = sum_sat;
        count_d = count_inc;
      end
    end
    res_d.min_ticks = min_d;
    res_d.max_ticks = max_d;
    res_d.avg_ticks = avg_d;
  end

  assign out_valid_d = ready_o ? valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b1;
      prev_q      <= 8'd0;
      min_q       <= 8'd0;
      max_q       <= 8'd0;
      avg_q       <= 8'd0;
      sum_q       <= 16'd0;
      count_q     <= 9'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take) begin
        pending_q <= pending_d;
        prev_q    <= prev_d;
        min_q     <= min_d;
        max_q     <= max_d;
        avg_q     <= avg_d;
        sum_q     <= sum_d;
        count_q   <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = res_q;

endmodule

### rtl/core/interval_min_max_average_tracker.sv
// Interval min/max/average tracker: measures intervals between timer snapshots and keeps
// running minimum, maximum and windowed average. One word is accepted per clock when the
// result side keeps up; each accepted word passes through the input register, then the update
// stage with its result register. The statistics update for a word is a single
// compare/add/shift pass, so consecutive words see each other's state with no gap. Words
// with cmd = 1 request a restart; the next snapshot then reinitializes.
`timescale 1ns / 1ps
module interval_min_max_average_tracker import imtr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  imtr_in_if.sink         in_i,
  imtr_out_if.source      out_o
);

  imtr_in_t  in_word;
  imtr_in_t  stage_word;
  logic      stage_valid;
  logic      stage_ready;
  imtr_res_t res;

  assign in_word.cmd         = in_i.cmd;
  assign in_word.timer_value = in_i.timer_value;

  imtr_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .word_i  (in_word),
    .valid_o (stage_valid),
    .ready_i (stage_ready),
    .word_o  (stage_word)
  );

  imtr_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid),
    .ready_o (stage_ready),
    .word_i  (stage_word),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .res_o   (res)
  );

  assign out_o.elapsed_ticks = res.elapsed_ticks;
  assign out_o.min_ticks     = res.min_ticks;
  assign out_o.max_ticks     = res.max_ticks;
  assign out_o.avg_ticks     = res.avg_ticks;
  assign out_o.avg_updated   = res.avg_updated;

endmodule

### tb/imtr_stats_checker.sv
// Checker: predicts tracker results from accepted input words and compares result words.
`timescale 1ns / 1ps
module imtr_stats_checker import imtr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  imtr_in_if          in_mon_i,
  imtr_out_if         out_mon_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);

  logic        restart_armed;
  logic [7:0]  last_stamp;
  logic [7:0]  min_q;
  logic [7:0]  max_q;
  logic [7:0]  avg_q;
  logic [15:0] window_sum;
  logic [8:0]  window_cnt;

  imtr_res_t   expected_stats_q[$];
  imtr_res_t   exp_w;
  imtr_in_t    word_in;
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  assign mismatch_cnt_o = mismatches;
  assign pending_o      = outstanding;

  function automatic logic [7:0] ticks_between(logic [7:0] now_v, logic [7:0] last_v);
    if (now_v >= last_v) return now_v - last_v;
    return 8'(TIMER_PERIOD - int'(last_v - now_v));
  endfunction

  function imtr_res_t track_word(imtr_in_t w);
    imtr_res_t r;
    int        sum_next;
    int        quo;
    r = '0;
    if (w.cmd == CMD_RESTART) begin
      restart_armed = 1'b1;
    end else if (restart_armed) begin
      min_q         = 8'(TIMER_PERIOD);
      max_q         = '0;
      avg_q         = '0;
      window_sum    = '0;
      window_cnt    = '0;
      restart_armed = 1'b0;
      last_stamp    = w.timer_value;
    end else begin
      r.elapsed_ticks = ticks_between(w.timer_value, last_stamp);
      if (r.elapsed_ticks < min_q) min_q = r.elapsed_ticks;
      if (r.elapsed_ticks > max_q) max_q = r.elapsed_ticks;
      sum_next   = int'(window_sum) + int'(r.elapsed_ticks);
      window_sum = (sum_next > 65535) ? 16'hFFFF : 16'(sum_next);
      window_cnt = window_cnt + 9'd1;
      if (int'(window_cnt) > AVG_WINDOW) begin
        quo           = int'(window_sum) / (AVG_WINDOW + 1);
        avg_q         = (quo > 255) ? 8'hFF : 8'(quo);
        window_sum    = '0;
        window_cnt    = '0;
        r.avg_updated = 1'b1;
      end
      last_stamp = w.timer_value;
    end
    r.min_ticks = min_q;
    r.max_ticks = max_q;
    r.avg_ticks = avg_q;
    return r;
  endfunction

  task automatic check_field(string field, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %0d, got %0d", field, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_armed = 1'b1;
      last_stamp    = '0;
      min_q         = '0;
      max_q         = '0;
      avg_q         = '0;
      window_sum    = '0;
      window_cnt    = '0;
      expected_stats_q.delete();
      outstanding   = 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (expected_stats_q.size() == 0) begin
          $error("result word with no expected word pending");
          mismatches++;
        end else begin
          exp_w = expected_stats_q.pop_front();
          outstanding--;
          check_field("elapsed_ticks", exp_w.elapsed_ticks, out_mon_i.elapsed_ticks);
          check_field("min_ticks", exp_w.min_ticks, out_mon_i.min_ticks);
          check_field("max_ticks", exp_w.max_ticks, out_mon_i.max_ticks);
          check_field("avg_ticks", exp_w.avg_ticks, out_mon_i.avg_ticks);
          check_field("avg_updated", 8'(exp_w.avg_updated), 8'(out_mon_i.avg_updated));
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        word_in.cmd         = in_mon_i.cmd;
        word_in.timer_value = in_mon_i.timer_value;
        expected_stats_q.push_back(track_word(word_in));
        outstanding++;
      end
    end
  end

endmodule

### tb/interval_min_max_average_tracker_test.sv
// Testbench top: clock, reset, stimulus, result-side flow control and verdict for the tracker.
`timescale 1ns / 1ps
module interval_min_max_average_tracker_test;
  import imtr_pkg::*;

  localparam int unsigned TOTAL_WORDS  = 1300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef enum logic [1:0] {
    STEP_RANDOM,
    STEP_FIXED,
    STEP_JITTER,
    STEP_BACK
  } step_style_e;

  logic        clk_i;
  logic        rst_ni;
  logic        no_idle;
  logic        hold_req;
  logic        hold_done;
  logic        drain_done;
  int unsigned words_sent;
  int unsigned stall_cycles;
  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  imtr_in_if  in_if ();
  imtr_out_if out_if ();

  interval_min_max_average_tracker DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  imtr_stats_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon_i       (in_if),
    .out_mon_i      (out_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic send_word(logic cmd_v, logic [7:0] stamp_v);
    no_idle = (words_sent >= 1000) && (words_sent < 1200);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 36) begin
      in_if.valid       <= 1'b0;
      in_if.cmd         <= 1'($urandom);
      in_if.timer_value <= 8'($urandom);
      @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.cmd         <= cmd_v;
    in_if.timer_value <= stamp_v;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  // restart, then a run of snapshots; some runs skip the restart or get a stray one
  task automatic run_burst();
    int unsigned run_len;
    int unsigned step;
    step_style_e style;
    logic [7:0]  stamp;
    if ($urandom_range(9) != 0) send_word(CMD_RESTART, 8'($urandom));
    run_len = ($urandom_range(3) == 0) ? $urandom_range(260, 600) : $urandom_range(1, 40);
    style   = step_style_e'($urandom_range(3));
    stamp   = 8'($urandom);
    step    = $urandom_range(255);
    for (int i = 0; i < run_len; i++) begin
      if (words_sent >= TOTAL_WORDS) break;
      case (style)
        STEP_RANDOM: stamp = 8'($urandom);
        STEP_FIXED:  stamp = stamp + 8'(step);
        STEP_JITTER: stamp = stamp + 8'($urandom_range(3));
        default:     stamp = stamp - 8'($urandom_range(3));
      endcase
      if ($urandom_range(99) < 2) send_word(CMD_RESTART, 8'($urandom));
      send_word(CMD_SNAPSHOT, stamp);
    end
  endtask

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_if.ready <= no_idle || ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("** interval_min_max_average_tracker: FAILED **");
    $finish;
  end

  initial begin
    in_if.valid       = 1'b0;
    in_if.cmd         = CMD_SNAPSHOT;
    in_if.timer_value = '0;
    no_idle           = 1'b0;
    hold_req          = 1'b0;
    hold_done         = 1'b0;
    drain_done        = 1'b0;
    words_sent        = 0;
    rst_ni            = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_word(CMD_RESTART, 8'hFF);   // restart while one is already pending
    send_word(CMD_SNAPSHOT, 8'h00);  // restart snapshot
    send_word(CMD_SNAPSHOT, 8'h00);  // zero interval
    send_word(CMD_SNAPSHOT, 8'hFF);  // largest interval
    send_word(CMD_SNAPSHOT, 8'h00);  // wrap across the whole range
    send_word(CMD_SNAPSHOT, 8'hC8);
    send_word(CMD_SNAPSHOT, 8'h64);  // wrap
    send_word(CMD_SNAPSHOT, 8'h65);
    send_word(CMD_RESTART, 8'h55);
    send_word(CMD_RESTART, 8'hAA);   // back-to-back restarts
    send_word(CMD_SNAPSHOT, 8'hAA);
    send_word(CMD_SNAPSHOT, 8'h55);  // wrap
    send_word(CMD_SNAPSHOT, 8'hFE);
    send_word(CMD_SNAPSHOT, 8'hFF);
    send_word(CMD_SNAPSHOT, 8'hFE);  // wrap by one tick
    send_word(CMD_SNAPSHOT, 8'h01);

    while (words_sent < TOTAL_WORDS) begin
      if (!hold_done && words_sent > 300) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (!drain_done && words_sent > 700) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        while (pending_cnt != 0) @(negedge clk_i);
        drain_done = 1'b1;
      end
      run_burst();
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("** interval_min_max_average_tracker: PASSED **");
    end else begin
      $display("** interval_min_max_average_tracker: FAILED **");
    end
    $finish;
  end

endmodule
